>>> rtl/core/dfsf_pkg.sv
// ----------------------------------------------------------------------------
// dfsf_pkg
// Shared types and constants for the depth-first search forest unit.
// ----------------------------------------------------------------------------
package dfsf_pkg;

    localparam int KIND_W    = 2;
    localparam int VERTEX_W  = 6;
    localparam int CFG_W     = 7;
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 16;

    localparam logic [CFG_W-1:0] VC_RESET = 7'd64;

    typedef enum logic [KIND_W-1:0] {
        KIND_EDGE  = 2'd0,
        KIND_RUN   = 2'd1,
        KIND_CLEAR = 2'd2
    } kind_t;

endpackage

>>> rtl/core/dfsf_pri_enc.sv
// ----------------------------------------------------------------------------
// dfsf_pri_enc
// Lowest-set-bit finder shared by the root scan and the neighbor scan.
// ----------------------------------------------------------------------------
module dfsf_pri_enc #(
    parameter int W = 64
) (
    input  logic [W-1:0]         req,
    output logic                 found,
    output logic [$clog2(W)-1:0] idx
);

    localparam int IW = $clog2(W);

    always_comb begin
        found = |req;
        idx   = '0;
        for (int i = W - 1; i >= 0; i--) begin
            if (req[i]) begin
                idx = IW'(i);
            end
        end
    end

endmodule

>>> rtl/core/dfsf_adj_ram.sv
// ----------------------------------------------------------------------------
// dfsf_adj_ram
// Adjacency row memory with one valid bit per row; an invalid row reads as
// zero, so a clear resets only the valid bits and does not rewrite the rows.
// ----------------------------------------------------------------------------
module dfsf_adj_ram #(
    parameter int NV = 64
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  clear,
    input  logic                  wr_en,
    input  logic [$clog2(NV)-1:0] wr_addr,
    input  logic [NV-1:0]         wr_row,
    input  logic [$clog2(NV)-1:0] rd_addr,
    output logic [NV-1:0]         rd_row
);

    logic [NV-1:0] mem [NV];
    logic [NV-1:0] row_ok_reg;
    logic [NV-1:0] rd_data_reg;
    logic          rd_ok_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_row;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_ok_reg <= '0;
            rd_ok_reg  <= 1'b0;
        end else begin
            rd_ok_reg <= row_ok_reg[rd_addr];
            if (clear) begin
                row_ok_reg <= '0;
            end else if (wr_en) begin
                row_ok_reg[wr_addr] <= 1'b1;
            end
        end
    end

    assign rd_row = rd_ok_reg ? rd_data_reg : '0;

endmodule

>>> rtl/core/depth_first_search_forest_unit.sv
// ----------------------------------------------------------------------------
// Depth-first search forest unit: an edge write reads and rewrites its row; a
// clear is done on acceptance. A run scans for roots, then pushes tree edges
// and pops the stack, bounded by the single adjacency row read port and the
// one shared priority encoder, then sends one result per vertex, held through
// any output stall. Items are taken one at a time. Synchronous reset (aresetn
// low) empties the matrix, sets vertex_count to 64 and idles.
// ----------------------------------------------------------------------------
module depth_first_search_forest_unit #(
    parameter int MAX_VERTICES = 64
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [dfsf_pkg::CFG_W-1:0]      cfg_wdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // from_vertex[5:0], to_vertex[11:6], edge_present[12], zero fill above.
    input  logic [dfsf_pkg::S_TDATA_W-1:0]  s_tdata,
    // kind[1:0].
    input  logic [dfsf_pkg::KIND_W-1:0]     s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // vertex[5:0], parent[11:6], zero fill above.
    output logic [dfsf_pkg::M_TDATA_W-1:0]  m_tdata,
    // is_root[0].
    output logic                            m_tuser,
    output logic                            m_tlast
);

    localparam int NV = (MAX_VERTICES < 64) ? MAX_VERTICES : 64;
    localparam int VW = $clog2(NV);
    localparam int NW = $clog2(NV + 1);
    localparam int CW = dfsf_pkg::CFG_W;

    typedef enum logic [3:0] {
        ST_IDLE, ST_EW_RD, ST_EW_WR, ST_ROOT, ST_ROW_RD, ST_SCAN, ST_POP,
        ST_OUT_RD, ST_OUT_SEND
    } state_t;

    state_t          state_reg;
    logic [CW-1:0]   vc_reg;
    logic [NW-1:0]   n_reg;
    logic [NW-1:0]   n_next;
    logic [NV-1:0]   visited_reg;
    logic [NV-1:0]   pvalid_reg;
    logic [VW-1:0]   cur_reg;
    logic [NW-1:0]   sp_reg;
    logic [VW-1:0]   out_idx_reg;
    logic [VW-1:0]   ew_from_reg;
    logic [VW-1:0]   ew_to_reg;
    logic            ew_present_reg;
    logic            m_tvalid_reg;

    logic [VW-1:0]   stk_mem [NV];
    logic [VW-1:0]   stk_rd_reg;
    logic [VW-1:0]   par_mem [NV];
    logic [VW-1:0]   par_rd_reg;

    logic [NV-1:0]   nmask;
    logic [NV-1:0]   adj_row;
    logic [NV-1:0]   adj_wr_row;
    logic [VW-1:0]   adj_rd_addr;
    logic            adj_clear;
    logic            adj_wr_en;
    logic [NV-1:0]   enc_req;
    logic            enc_found;
    logic [VW-1:0]   enc_idx;
    logic            push_en;
    logic            s_xfer;
    logic            m_xfer;
    logic            edge_ok;
    logic            out_last;
    logic            out_root;
    dfsf_pkg::kind_t s_kind;

    logic [dfsf_pkg::VERTEX_W-1:0] s_from;
    logic [dfsf_pkg::VERTEX_W-1:0] s_to;

    assign s_kind  = dfsf_pkg::kind_t'(s_tuser);
    assign s_from  = s_tdata[5:0];
    assign s_to    = s_tdata[11:6];
    assign s_xfer  = s_tvalid && s_tready;
    assign m_xfer  = m_tvalid_reg && m_tready;
    assign edge_ok = ({1'b0, s_from} < CW'(NV)) && ({1'b0, s_to} < CW'(NV));

    always_comb begin
        if (vc_reg == '0) begin
            n_next = NW'(1);
        end else if (vc_reg > CW'(NV)) begin
            n_next = NW'(NV);
        end else begin
            n_next = NW'(vc_reg);
        end
    end

    always_comb begin
        for (int i = 0; i < NV; i++) begin
            nmask[i] = (CW'(i) < CW'(n_reg));
        end
    end

    always_comb begin
        if (state_reg == ST_ROOT) begin
            enc_req = ~visited_reg & nmask;
        end else begin
            enc_req = adj_row & ~visited_reg & nmask;
        end
    end

    dfsf_pri_enc #(
        .W     (NV)
    ) u_enc (
        .req   (enc_req),
        .found (enc_found),
        .idx   (enc_idx)
    );

    always_comb begin
        adj_wr_row            = adj_row;
        adj_wr_row[ew_to_reg] = ew_present_reg;
    end

    assign adj_rd_addr = (state_reg == ST_EW_RD) ? ew_from_reg : cur_reg;
    assign adj_clear   = s_xfer && (s_kind == dfsf_pkg::KIND_CLEAR);
    assign adj_wr_en   = (state_reg == ST_EW_WR);

    dfsf_adj_ram #(
        .NV      (NV)
    ) u_adj (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clear   (adj_clear),
        .wr_en   (adj_wr_en),
        .wr_addr (ew_from_reg),
        .wr_row  (adj_wr_row),
        .rd_addr (adj_rd_addr),
        .rd_row  (adj_row)
    );

    assign push_en = (state_reg == ST_SCAN) && enc_found;

    always_ff @(posedge aclk) begin
        if (push_en) begin
            stk_mem[sp_reg[VW-1:0]] <= cur_reg;
            par_mem[enc_idx]        <= cur_reg;
        end
        stk_rd_reg <= stk_mem[VW'(sp_reg - NW'(1))];
        par_rd_reg <= par_mem[out_idx_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            vc_reg       <= dfsf_pkg::VC_RESET;
            n_reg        <= NW'(NV);
            visited_reg  <= '0;
            pvalid_reg   <= '0;
            cur_reg      <= '0;
            sp_reg       <= '0;
            out_idx_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                vc_reg <= cfg_wdata;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_xfer) begin
                        case (s_kind)
                            dfsf_pkg::KIND_EDGE: begin
                                ew_from_reg    <= s_from[VW-1:0];
                                ew_to_reg      <= s_to[VW-1:0];
                                ew_present_reg <= s_tdata[12];
                                if (edge_ok) begin
                                    state_reg <= ST_EW_RD;
                                end
                            end
                            dfsf_pkg::KIND_RUN: begin
                                visited_reg <= '0;
                                pvalid_reg  <= '0;
                                sp_reg      <= '0;
                                n_reg       <= n_next;
                                state_reg   <= ST_ROOT;
                            end
                            default: begin
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_EW_RD: begin
                    state_reg <= ST_EW_WR;
                end
                ST_EW_WR: begin
                    state_reg <= ST_IDLE;
                end
                ST_ROOT: begin
                    if (enc_found) begin
                        visited_reg[enc_idx] <= 1'b1;
                        cur_reg              <= enc_idx;
                        state_reg            <= ST_ROW_RD;
                    end else begin
                        out_idx_reg <= '0;
                        state_reg   <= ST_OUT_RD;
                    end
                end
                ST_ROW_RD: begin
                    state_reg <= ST_SCAN;
                end
                ST_SCAN: begin
                    if (enc_found) begin
                        visited_reg[enc_idx] <= 1'b1;
                        pvalid_reg[enc_idx]  <= 1'b1;
                        cur_reg              <= enc_idx;
                        sp_reg               <= sp_reg + NW'(1);
                        state_reg            <= ST_ROW_RD;
                    end else if (sp_reg == '0) begin
                        state_reg <= ST_ROOT;
                    end else begin
                        sp_reg    <= sp_reg - NW'(1);
                        state_reg <= ST_POP;
                    end
                end
                ST_POP: begin
                    cur_reg   <= stk_rd_reg;
                    state_reg <= ST_ROW_RD;
                end
                ST_OUT_RD: begin
                    m_tvalid_reg <= 1'b1;
                    state_reg    <= ST_OUT_SEND;
                end
                ST_OUT_SEND: begin
                    if (m_xfer) begin
                        m_tvalid_reg <= 1'b0;
                        if (out_last) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            out_idx_reg <= out_idx_reg + VW'(1);
                            state_reg   <= ST_OUT_RD;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_last = ((NW'(out_idx_reg) + NW'(1)) == n_reg);
    assign out_root = !pvalid_reg[out_idx_reg];

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_root;
    assign m_tlast  = out_last;
    assign m_tdata  = {4'b0000,
                       out_root ? 6'd0 : dfsf_pkg::VERTEX_W'(par_rd_reg),
                       dfsf_pkg::VERTEX_W'(out_idx_reg)};

endmodule

>>> rtl/core/dfsf_checker.sv
// ----------------------------------------------------------------------------
// dfsf_checker
// Port-level checks on the depth-first search forest unit, bound to the top.
// ----------------------------------------------------------------------------
module dfsf_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [dfsf_pkg::KIND_W-1:0]     s_tuser,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [dfsf_pkg::M_TDATA_W-1:0]  m_tdata,
    input logic                            m_tuser,
    input logic                            m_tlast
);

    // The input side is never open while a result is on offer.
    a_busy_while_out: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input ready while a result is pending");

    // A run transfer closes the input side in the next cycle.
    a_run_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser == dfsf_pkg::KIND_RUN) |=> !s_tready)
        else $error("input still ready after a run transfer");

    // The last result of a run is followed by no further result.
    a_last_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> !m_tvalid)
        else $error("result offered right after the last transfer");

    // A root result carries a zero parent.
    a_root_parent: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata[11:6] == 6'd0))
        else $error("root result with nonzero parent");

    // A stalled result holds its payload.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=>
        (m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast)))
        else $error("result changed while stalled");

endmodule

bind depth_first_search_forest_unit dfsf_checker u_dfsf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

>>> tb/dfsf_forest_checker.sv
// ----------------------------------------------------------------------------
// dfsf_forest_checker
// Watches the configuration port and both streams of the depth-first search
// forest unit. It keeps its own copy of the adjacency matrix and the vertex
// count, grows the search forest for every run transfer, and compares each
// result transfer with the oldest parent report still owed.
// ----------------------------------------------------------------------------
module dfsf_forest_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [dfsf_pkg::CFG_W-1:0]      cfg_wdata,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    // from_vertex[5:0], to_vertex[11:6], edge_present[12], zero fill above.
    input  logic [dfsf_pkg::S_TDATA_W-1:0]  s_tdata,
    // kind[1:0].
    input  logic [dfsf_pkg::KIND_W-1:0]     s_tuser,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    // vertex[5:0], parent[11:6], zero fill above.
    input  logic [dfsf_pkg::M_TDATA_W-1:0]  m_tdata,
    // is_root[0].
    input  logic                            m_tuser,
    input  logic                            m_tlast,
    output int                              mismatch_count,
    output int                              reports_owed
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [dfsf_pkg::VERTEX_W-1:0] vertex;
        logic [dfsf_pkg::VERTEX_W-1:0] parent;
        logic                          is_root;
        logic                          last;
    } parent_report_t;

    logic [63:0]                  adjacency [64];
    logic [dfsf_pkg::CFG_W-1:0]   vertex_count_q;
    parent_report_t               parent_reports [$];

    task automatic grow_forest();
        int                            n;
        int                            depth;
        int                            v;
        int                            i;
        bit                            found;
        logic [63:0]                   seen;
        logic [63:0]                   has_parent;
        logic [dfsf_pkg::VERTEX_W-1:0] parent_of [64];
        int                            stack_vertex [64];
        int                            stack_next [64];
        parent_report_t                report;
        n = vertex_count_q;
        if (n < 1) n = 1;
        if (n > 64) n = 64;
        seen = '0;
        has_parent = '0;
        for (int k = 0; k < 64; k++) parent_of[k] = '0;
        for (int root = 0; root < n; root++) begin
            if (!seen[root]) begin
                seen[root] = 1'b1;
                stack_vertex[0] = root;
                stack_next[0] = 0;
                depth = 1;
                while (depth > 0) begin
                    v = stack_vertex[depth-1];
                    i = stack_next[depth-1];
                    found = 1'b0;
                    while (i < n && !found) begin
                        if (adjacency[v][i] && !seen[i]) found = 1'b1;
                        else i++;
                    end
                    if (found) begin
                        stack_next[depth-1] = i + 1;
                        seen[i] = 1'b1;
                        has_parent[i] = 1'b1;
                        parent_of[i] = dfsf_pkg::VERTEX_W'(v);
                        stack_vertex[depth] = i;
                        stack_next[depth] = 0;
                        depth++;
                    end else begin
                        depth--;
                    end
                end
            end
        end
        for (int r = 0; r < n; r++) begin
            report.vertex  = dfsf_pkg::VERTEX_W'(r);
            report.parent  = has_parent[r] ? parent_of[r] : '0;
            report.is_root = !has_parent[r];
            report.last    = (r == n - 1);
            parent_reports.insert(parent_reports.size(), report);
        end
    endtask

    task automatic check_report();
        parent_report_t want;
        parent_report_t got;
        got.vertex  = m_tdata[5:0];
        got.parent  = m_tdata[11:6];
        got.is_root = m_tuser;
        got.last    = m_tlast;
        if (parent_reports.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("%0t: result transfer with nothing owed:", $realtime,
                         " vertex %0d parent %0d root %0b last %0b",
                         got.vertex, got.parent, got.is_root, got.last);
        end else begin
            want = parent_reports.pop_front();
            if (got !== want) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: expected vertex %0d parent %0d root %0b last %0b,",
                             $realtime, want.vertex, want.parent, want.is_root, want.last,
                             " got vertex %0d parent %0d root %0b last %0b",
                             got.vertex, got.parent, got.is_root, got.last);
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < 64; k++) adjacency[k] = '0;
            vertex_count_q = dfsf_pkg::VC_RESET;
            parent_reports.delete();
            mismatch_count = 0;
        end else begin
            if (cfg_we) vertex_count_q = cfg_wdata;
            if (m_tvalid && m_tready) check_report();
            if (s_tvalid && s_tready) begin
                case (s_tuser)
                    dfsf_pkg::KIND_EDGE:
                        adjacency[s_tdata[5:0]][s_tdata[11:6]] = s_tdata[12];
                    dfsf_pkg::KIND_RUN:
                        grow_forest();
                    dfsf_pkg::KIND_CLEAR:
                        for (int k = 0; k < 64; k++) adjacency[k] = '0;
                    default: ;
                endcase
            end
        end
        reports_owed = parent_reports.size();
    end

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the depth-first search forest unit. A directed
// part covers the vertex count extremes, self loops, edge removal, unused
// vertices, clears and the unused kind; a random part then builds graphs of
// random size and shape and runs searches on them, with random gaps on the
// input stream and random stalls on the result stream.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [dfsf_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;

    logic                             aclk = 1'b0;
    logic                             aresetn;
    logic                             cfg_we;
    logic [dfsf_pkg::CFG_W-1:0]       cfg_wdata;
    logic                             s_tvalid;
    logic                             s_tready;
    logic [dfsf_pkg::S_TDATA_W-1:0]   s_tdata;
    logic [dfsf_pkg::KIND_W-1:0]      s_tuser;
    logic                             m_tvalid;
    logic                             m_tready;
    logic [dfsf_pkg::M_TDATA_W-1:0]   m_tdata;
    logic                             m_tuser;
    logic                             m_tlast;
    int                               mismatch_count;
    int                               reports_owed;
    bit                               calm;
    int                               items_sent;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    depth_first_search_forest_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    dfsf_forest_checker u_forest_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .m_tlast        (m_tlast),
        .mismatch_count (mismatch_count),
        .reports_owed   (reports_owed)
    );

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_item(input logic [dfsf_pkg::KIND_W-1:0] kind,
                             input logic [5:0] from_vertex,
                             input logic [5:0] to_vertex, input logic edge_present);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {3'b000, edge_present, to_vertex, from_vertex};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        items_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
    endtask

    task automatic write_vertex_count(input logic [dfsf_pkg::CFG_W-1:0] value);
        s_tvalid <= 1'b0;
        while (reports_owed != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we    <= 1'b0;
    endtask

    initial begin
        int stall;
        m_tready = 1'b0;
        stall = 0;
        forever begin
            @(negedge aclk);
            if (stall > 0) begin
                m_tready <= 1'b0;
                stall--;
            end else begin
                m_tready <= 1'b1;
                stall = pick_gap();
            end
        end
    end

    initial begin
        #50_000_000;
        $display("[depth_first_search_forest_unit] ERROR");
        $finish;
    end

    initial begin
        int r;
        int n_cur;
        int edges;
        logic [dfsf_pkg::CFG_W-1:0] vc;
        aresetn    = 1'b0;
        cfg_we     = 1'b0;
        cfg_wdata  = '0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = dfsf_pkg::KIND_EDGE;
        calm       = 1'b0;
        items_sent = 0;
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        send_item(dfsf_pkg::KIND_RUN,    6'd0,  6'd0,  1'b0);
        send_item(dfsf_pkg::KIND_EDGE,   6'd0,  6'd63, 1'b1);
        send_item(dfsf_pkg::KIND_EDGE,   6'd63, 6'd0,  1'b1);
        send_item(dfsf_pkg::KIND_EDGE,   6'd5,  6'd5,  1'b1);
        send_item(dfsf_pkg::KIND_EDGE,   6'd10, 6'd20, 1'b1);
        send_item(dfsf_pkg::KIND_EDGE,   6'd10, 6'd20, 1'b0);
        send_item(dfsf_pkg::KIND_EDGE,   6'd0,  6'd1,  1'b1);
        send_item(dfsf_pkg::KIND_EDGE,   6'd1,  6'd2,  1'b1);
        send_item(dfsf_pkg::KIND_EDGE,   6'd2,  6'd1,  1'b1);
        send_item(dfsf_pkg::KIND_EDGE,   6'd2,  6'd62, 1'b1);
        send_item(KIND_UNUSED,           6'd63, 6'd63, 1'b1);
        send_item(dfsf_pkg::KIND_RUN,    6'd63, 6'd63, 1'b1);
        send_item(dfsf_pkg::KIND_CLEAR,  6'd0,  6'd0,  1'b0);
        send_item(dfsf_pkg::KIND_RUN,    6'd0,  6'd0,  1'b0);
        write_vertex_count(7'd0);
        send_item(dfsf_pkg::KIND_EDGE,   6'd1,  6'd0,  1'b1);
        send_item(dfsf_pkg::KIND_RUN,    6'd0,  6'd0,  1'b0);
        write_vertex_count(7'd127);
        send_item(dfsf_pkg::KIND_EDGE,   6'd63, 6'd62, 1'b1);
        send_item(dfsf_pkg::KIND_RUN,    6'd0,  6'd0,  1'b0);
        write_vertex_count(7'd2);
        send_item(dfsf_pkg::KIND_EDGE,   6'd0,  6'd50, 1'b1);
        send_item(dfsf_pkg::KIND_RUN,    6'd0,  6'd0,  1'b0);
        send_item(dfsf_pkg::KIND_EDGE,   6'd0,  6'd1,  1'b1);
        send_item(dfsf_pkg::KIND_RUN,    6'd0,  6'd0,  1'b0);
        write_vertex_count(7'd65);
        send_item(dfsf_pkg::KIND_RUN,    6'd0,  6'd0,  1'b0);

        while (items_sent < 410) begin
            r = $urandom_range(0, 9);
            if (r == 0)      vc = 7'd0;
            else if (r == 1) vc = 7'd64;
            else if (r == 2) vc = 7'($urandom_range(65, 127));
            else if (r == 3) vc = 7'd1;
            else if (r == 4) vc = 7'($urandom_range(33, 63));
            else             vc = 7'($urandom_range(2, 16));
            write_vertex_count(vc);
            calm = ($urandom_range(0, 4) == 0);
            n_cur = (vc < 1) ? 1 : (vc > 64) ? 64 : vc;
            if ($urandom_range(0, 2) == 0)
                send_item(dfsf_pkg::KIND_CLEAR, 6'($urandom), 6'($urandom), 1'($urandom));
            edges = $urandom_range(1, (2 * n_cur < 30) ? 2 * n_cur : 30);
            repeat (edges) begin
                r = $urandom_range(0, 9);
                if (r < 8)
                    send_item(dfsf_pkg::KIND_EDGE, 6'($urandom_range(0, n_cur - 1)),
                              6'($urandom_range(0, n_cur - 1)), $urandom_range(0, 3) != 0);
                else if (r == 8)
                    send_item(dfsf_pkg::KIND_EDGE, 6'($urandom), 6'($urandom), 1'($urandom));
                else
                    send_item(KIND_UNUSED, 6'($urandom), 6'($urandom), 1'($urandom));
            end
            send_item(dfsf_pkg::KIND_RUN, 6'($urandom), 6'($urandom), 1'($urandom));
            if ($urandom_range(0, 2) == 0)
                send_item(dfsf_pkg::KIND_RUN, 6'($urandom), 6'($urandom), 1'($urandom));
        end

        s_tvalid <= 1'b0;
        while (reports_owed != 0) @(negedge aclk);
        repeat (100) @(negedge aclk);
        if (mismatch_count == 0)
            $display("[depth_first_search_forest_unit] OK");
        else
            $display("[depth_first_search_forest_unit] ERROR");
        $finish;
    end

endmodule

>>> depth_first_search_forest_unit.f
rtl/core/dfsf_pkg.sv
rtl/core/dfsf_pri_enc.sv
rtl/core/dfsf_adj_ram.sv
rtl/core/depth_first_search_forest_unit.sv
rtl/core/dfsf_checker.sv
tb/dfsf_forest_checker.sv
tb/tb_top.sv
